[src/rpi_pkg.sv]
// rpi_pkg: shared types, widths, codes and arithmetic helpers for the
// ray / parallelogram intersection pipeline. No dependencies.
package rpi_pkg;

    // field and datapath widths
    localparam int COORD_W   = 16;
    localparam int W_W       = COORD_W + 1;
    localparam int N_W       = 2 * COORD_W + 1;
    localparam int C_W       = 2 * COORD_W + 2;
    localparam int DOT_W     = 3 * COORD_W + 4;
    localparam int MAG_W     = DOT_W;
    localparam int REG_W     = 3 * COORD_W;
    localparam int DIST_W    = 32;
    localparam int UV_W      = 17;
    localparam int T_Q_W     = DIST_W - 1;
    localparam int T_STEPS   = T_Q_W;
    localparam int UV_STEPS  = UV_W;
    localparam int T_LO_W    = 15;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CORNER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_U = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_V = 2'd2;

    // saturation limits of the distance field
    localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_OUTSIDE  = 2'd2
    } status_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [W_W-1:0]     wcoord_t;
    typedef logic signed [N_W-1:0]     ncoord_t;
    typedef logic signed [C_W-1:0]     xcoord_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic [MAG_W-1:0]          mag_t;

    // x in the low bits, matching the register packing
    typedef struct packed { coord_t  z; coord_t  y; coord_t  x; } cvec_t;
    typedef struct packed { wcoord_t z; wcoord_t y; wcoord_t x; } wvec_t;
    typedef struct packed { ncoord_t z; ncoord_t y; ncoord_t x; } nvec_t;
    typedef struct packed { xcoord_t z; xcoord_t y; xcoord_t x; } xvec_t;

    typedef struct packed {
        cvec_t corner;
        cvec_t edge_u;
        cvec_t edge_v;
    } shape_t;

    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t dir_x;
        coord_t dir_y;
        coord_t dir_z;
    } ray_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DIST_W-1:0] distance;
        logic [UV_W-1:0]          coord_u;
        logic [UV_W-1:0]          coord_v;
    } result_t;

    // state carried down the divider stages; all three quotients share den
    typedef struct packed {
        status_t            status;
        logic               t_neg;
        logic               t_sat;
        mag_t               den;
        mag_t               t_r;
        logic [T_LO_W-1:0]  t_lo;
        logic [T_Q_W-1:0]   t_q;
        mag_t               u_r;
        logic               u_b;
        logic [UV_W-1:0]    u_q;
        mag_t               v_r;
        logic               v_b;
        logic [UV_W-1:0]    v_q;
    } div_state_t;

    typedef struct packed {
        mag_t r;
        logic q;
    } step_t;

    // edge cross product
    function automatic nvec_t cross_ee(cvec_t a, cvec_t b);
        nvec_t r;
        r.x = N_W'(a.y) * N_W'(b.z) - N_W'(a.z) * N_W'(b.y);
        r.y = N_W'(a.z) * N_W'(b.x) - N_W'(a.x) * N_W'(b.z);
        r.z = N_W'(a.x) * N_W'(b.y) - N_W'(a.y) * N_W'(b.x);
        return r;
    endfunction

    // edge x offset
    function automatic xvec_t cross_ew(cvec_t e, wvec_t w);
        xvec_t r;
        r.x = C_W'(e.y) * C_W'(w.z) - C_W'(e.z) * C_W'(w.y);
        r.y = C_W'(e.z) * C_W'(w.x) - C_W'(e.x) * C_W'(w.z);
        r.z = C_W'(e.x) * C_W'(w.y) - C_W'(e.y) * C_W'(w.x);
        return r;
    endfunction

    // offset x edge
    function automatic xvec_t cross_we(wvec_t w, cvec_t e);
        xvec_t r;
        r.x = C_W'(w.y) * C_W'(e.z) - C_W'(w.z) * C_W'(e.y);
        r.y = C_W'(w.z) * C_W'(e.x) - C_W'(w.x) * C_W'(e.z);
        r.z = C_W'(w.x) * C_W'(e.y) - C_W'(w.y) * C_W'(e.x);
        return r;
    endfunction

    function automatic dot_t dot_dn(cvec_t d, nvec_t n);
        return DOT_W'(d.x) * DOT_W'(n.x) + DOT_W'(d.y) * DOT_W'(n.y)
             + DOT_W'(d.z) * DOT_W'(n.z);
    endfunction

    function automatic dot_t dot_wn(wvec_t w, nvec_t n);
        return DOT_W'(w.x) * DOT_W'(n.x) + DOT_W'(w.y) * DOT_W'(n.y)
             + DOT_W'(w.z) * DOT_W'(n.z);
    endfunction

    function automatic dot_t dot_dx(cvec_t d, xvec_t c);
        return DOT_W'(d.x) * DOT_W'(c.x) + DOT_W'(d.y) * DOT_W'(c.y)
             + DOT_W'(d.z) * DOT_W'(c.z);
    endfunction

    function automatic mag_t abs_dot(dot_t v);
        dot_t n;
        n = -v;
        return v[DOT_W-1] ? mag_t'(n) : mag_t'(v);
    endfunction

    // one restoring division step: shift in one dividend bit, try subtract
    function automatic step_t div_step(mag_t r, mag_t d, logic b);
        logic [MAG_W:0] s;
        logic [MAG_W:0] dd;
        step_t res;
        s  = {r, b};
        dd = {1'b0, d};
        if (s >= dd)
        begin
            res.r = MAG_W'(s - dd);
            res.q = 1'b1;
        end
        else
        begin
            res.r = MAG_W'(s);
            res.q = 1'b0;
        end
        return res;
    endfunction

endpackage

[src/rpi_front.sv]
// rpi_front: four pipeline stages of vector maths and classification,
// producing the divider start state. Depends on rpi_pkg.
module rpi_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  rpi_pkg::ray_t       in_data,
    input  rpi_pkg::shape_t     shape,
    output logic                out_valid,
    output rpi_pkg::div_state_t out_data
);

    // stage 1: offset and cross products
    logic                s1_valid_reg;
    rpi_pkg::cvec_t      s1_d_reg, s1_d_next;
    rpi_pkg::wvec_t      s1_w_reg, s1_w_next;
    rpi_pkg::nvec_t      s1_n_reg, s1_n_next;
    rpi_pkg::xvec_t      s1_cu_reg, s1_cu_next;
    rpi_pkg::xvec_t      s1_cv_reg, s1_cv_next;

    // stage 2: triple products
    logic                s2_valid_reg;
    rpi_pkg::dot_t       s2_det_reg, s2_det_next;
    rpi_pkg::dot_t       s2_tn_reg, s2_tn_next;
    rpi_pkg::dot_t       s2_un_reg, s2_un_next;
    rpi_pkg::dot_t       s2_vn_reg, s2_vn_next;

    // stage 3: sign and magnitude
    logic                s3_valid_reg;
    rpi_pkg::mag_t       s3_md_reg, s3_mt_reg, s3_mu_reg, s3_mv_reg;
    logic                s3_nd_reg, s3_nt_reg, s3_nu_reg, s3_nv_reg;

    // stage 4: classification and divider start
    logic                s4_valid_reg;
    rpi_pkg::div_state_t s4_reg, s4_next;
    logic                u_bad, v_bad;

    // stage 1 logic
    always_comb
    begin
        s1_d_next.x = in_data.dir_x;
        s1_d_next.y = in_data.dir_y;
        s1_d_next.z = in_data.dir_z;
        s1_w_next.x = rpi_pkg::W_W'(shape.corner.x) - rpi_pkg::W_W'(in_data.origin_x);
        s1_w_next.y = rpi_pkg::W_W'(shape.corner.y) - rpi_pkg::W_W'(in_data.origin_y);
        s1_w_next.z = rpi_pkg::W_W'(shape.corner.z) - rpi_pkg::W_W'(in_data.origin_z);
        s1_n_next   = rpi_pkg::cross_ee(shape.edge_u, shape.edge_v);
        s1_cu_next  = rpi_pkg::cross_ew(shape.edge_v, s1_w_next);
        s1_cv_next  = rpi_pkg::cross_we(s1_w_next, shape.edge_u);
    end

    // stage 2 logic
    always_comb
    begin
        s2_det_next = rpi_pkg::dot_dn(s1_d_reg, s1_n_reg);
        s2_tn_next  = rpi_pkg::dot_wn(s1_w_reg, s1_n_reg);
        s2_un_next  = rpi_pkg::dot_dx(s1_d_reg, s1_cu_reg);
        s2_vn_next  = rpi_pkg::dot_dx(s1_d_reg, s1_cv_reg);
    end

    // stage 4 logic: u and v must share the sign of det and not exceed it
    always_comb
    begin
        u_bad = ((s3_mu_reg != '0) && (s3_nu_reg != s3_nd_reg)) || (s3_mu_reg > s3_md_reg);
        v_bad = ((s3_mv_reg != '0) && (s3_nv_reg != s3_nd_reg)) || (s3_mv_reg > s3_md_reg);
        if (s3_md_reg == '0)
        begin
            s4_next.status = rpi_pkg::ST_PARALLEL;
        end
        else if (u_bad || v_bad)
        begin
            s4_next.status = rpi_pkg::ST_OUTSIDE;
        end
        else
        begin
            s4_next.status = rpi_pkg::ST_HIT;
        end
        s4_next.t_neg = (s3_mt_reg != '0) && (s3_nt_reg != s3_nd_reg);
        s4_next.t_sat = (s3_mt_reg >> rpi_pkg::T_LO_W) >= s3_md_reg;
        s4_next.den   = s3_md_reg;
        s4_next.t_r   = s3_mt_reg >> rpi_pkg::T_LO_W;
        s4_next.t_lo  = s3_mt_reg[rpi_pkg::T_LO_W-1:0];
        s4_next.t_q   = '0;
        s4_next.u_r   = s3_mu_reg >> 1;
        s4_next.u_b   = s3_mu_reg[0];
        s4_next.u_q   = '0;
        s4_next.v_r   = s3_mv_reg >> 1;
        s4_next.v_b   = s3_mv_reg[0];
        s4_next.v_q   = '0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_d_reg   <= s1_d_next;
            s1_w_reg   <= s1_w_next;
            s1_n_reg   <= s1_n_next;
            s1_cu_reg  <= s1_cu_next;
            s1_cv_reg  <= s1_cv_next;
            s2_det_reg <= s2_det_next;
            s2_tn_reg  <= s2_tn_next;
            s2_un_reg  <= s2_un_next;
            s2_vn_reg  <= s2_vn_next;
            s3_md_reg  <= rpi_pkg::abs_dot(s2_det_reg);
            s3_mt_reg  <= rpi_pkg::abs_dot(s2_tn_reg);
            s3_mu_reg  <= rpi_pkg::abs_dot(s2_un_reg);
            s3_mv_reg  <= rpi_pkg::abs_dot(s2_vn_reg);
            s3_nd_reg  <= s2_det_reg[rpi_pkg::DOT_W-1];
            s3_nt_reg  <= s2_tn_reg[rpi_pkg::DOT_W-1];
            s3_nu_reg  <= s2_un_reg[rpi_pkg::DOT_W-1];
            s3_nv_reg  <= s2_vn_reg[rpi_pkg::DOT_W-1];
            s4_reg     <= s4_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_data  = s4_reg;

endmodule

[src/rpi_div_pipe.sv]
// rpi_div_pipe: pipelined restoring divider, one quotient bit per stage,
// t over all stages and u, v over the first ones. Depends on rpi_pkg.
module rpi_div_pipe (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  rpi_pkg::div_state_t in_data,
    output logic                out_valid,
    output rpi_pkg::div_state_t out_data
);

    rpi_pkg::div_state_t stage_reg [rpi_pkg::T_STEPS];
    logic                valid_reg [rpi_pkg::T_STEPS];

    for (genvar j = 0; j < rpi_pkg::T_STEPS; j++)
    begin : g_stage
        rpi_pkg::div_state_t src;
        rpi_pkg::div_state_t stage_next;
        logic                src_valid;
        rpi_pkg::step_t      t_step, u_step, v_step;

        if (j == 0)
        begin : g_head
            assign src       = in_data;
            assign src_valid = in_valid;
        end
        else
        begin : g_body
            assign src       = stage_reg[j-1];
            assign src_valid = valid_reg[j-1];
        end

        // one bit of each quotient
        always_comb
        begin
            t_step = rpi_pkg::div_step(src.t_r, src.den, src.t_lo[rpi_pkg::T_LO_W-1]);
            u_step = rpi_pkg::div_step(src.u_r, src.den, src.u_b);
            v_step = rpi_pkg::div_step(src.v_r, src.den, src.v_b);
            stage_next      = src;
            stage_next.t_r  = t_step.r;
            stage_next.t_lo = src.t_lo << 1;
            stage_next.t_q  = {src.t_q[rpi_pkg::T_Q_W-2:0], t_step.q};
            if (j < rpi_pkg::UV_STEPS)
            begin
                stage_next.u_r = u_step.r;
                stage_next.u_b = 1'b0;
                stage_next.u_q = {src.u_q[rpi_pkg::UV_W-2:0], u_step.q};
                stage_next.v_r = v_step.r;
                stage_next.v_b = 1'b0;
                stage_next.v_q = {src.v_q[rpi_pkg::UV_W-2:0], v_step.q};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[j] <= stage_next;
            end
        end
    end

    assign out_valid = valid_reg[rpi_pkg::T_STEPS-1];
    assign out_data  = stage_reg[rpi_pkg::T_STEPS-1];

endmodule

[src/rpi_out.sv]
// rpi_out: result formatting, output register and one-entry skid buffer;
// also drives the pipeline advance. Depends on rpi_pkg.
module rpi_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rpi_pkg::div_state_t in_data,
    output logic                en,
    output logic                out_valid,
    input  logic                out_ready,
    output rpi_pkg::result_t    out_data
);

    rpi_pkg::result_t fmt;
    logic [rpi_pkg::DIST_W-1:0] q32;
    logic                take;
    logic                out_free;

    logic                out_valid_reg, out_valid_next;
    rpi_pkg::result_t    out_data_reg, out_data_next;
    logic                skid_full_reg, skid_full_next;
    rpi_pkg::result_t    skid_data_reg, skid_data_next;

    // format: saturate and sign t, zero everything on a miss
    always_comb
    begin
        q32 = {1'b0, in_data.t_q};
        fmt.status   = in_data.status;
        fmt.distance = '0;
        fmt.coord_u  = '0;
        fmt.coord_v  = '0;
        if (in_data.status == rpi_pkg::ST_HIT)
        begin
            if (in_data.t_sat)
            begin
                fmt.distance = in_data.t_neg ? rpi_pkg::DIST_MIN : rpi_pkg::DIST_MAX;
            end
            else
            begin
                fmt.distance = in_data.t_neg ? -q32 : q32;
            end
            fmt.coord_u = in_data.u_q;
            fmt.coord_v = in_data.v_q;
        end
    end

    // output register and skid control
    always_comb
    begin
        take           = in_valid && !skid_full_reg;
        out_free       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        skid_full_next = skid_full_reg;
        skid_data_next = skid_data_reg;
        if (skid_full_reg)
        begin
            if (out_ready)
            begin
                out_data_next  = skid_data_reg;
                skid_full_next = 1'b0;
            end
        end
        else if (take)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = fmt;
            end
            else
            begin
                skid_full_next = 1'b1;
                skid_data_next = fmt;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign en        = !skid_full_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/ray_parallelogram_intersect_top.sv]
// Ray / parallelogram intersection test, fully pipelined. One ray request
// is accepted every cycle while in_ready is high; each gives exactly one
// result, which passes 36 register stages on its way to the output (4 of
// vector maths, 31 divider stages, 1 output register, the first loaded at
// the accepting edge). Most of the depth lies in the 31-stage bit-per-stage
// divider for t. in_ready drops only while a result is held
// in the one-entry skid buffer because out_ready was low. The parallelogram
// (corner, edge u, edge v, three signed Q8.8 components each, x in the low
// bits) is written through the config port and must only change while no
// request is in flight.
// Depends on rpi_pkg, rpi_front, rpi_div_pipe, rpi_out.
module ray_parallelogram_intersect_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [rpi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpi_pkg::REG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rpi_pkg::ray_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rpi_pkg::result_t                  out_data
);

    rpi_pkg::shape_t     shape_reg;
    logic                en;
    logic                front_valid;
    rpi_pkg::div_state_t front_data;
    logic                div_valid;
    rpi_pkg::div_state_t div_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rpi_pkg::REG_CORNER: shape_reg.corner <= rpi_pkg::cvec_t'(cfg_data);
                rpi_pkg::REG_EDGE_U: shape_reg.edge_u <= rpi_pkg::cvec_t'(cfg_data);
                rpi_pkg::REG_EDGE_V: shape_reg.edge_v <= rpi_pkg::cvec_t'(cfg_data);
                default: ;
            endcase
        end
    end

    rpi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .shape     (shape_reg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    rpi_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    rpi_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .en        (en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign in_ready = en;

endmodule

[src/rpi_checker.sv]
// rpi_checker: port-level assertions for the intersection block, bound to
// the top level. Depends on rpi_pkg and ray_parallelogram_intersect_top.
module rpi_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input rpi_pkg::result_t out_data
);

    // a miss or parallel ray carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != rpi_pkg::ST_HIT)
        |-> (out_data.distance == '0) && (out_data.coord_u == '0)
            && (out_data.coord_v == '0))
        else $error("non-hit result with non-zero fields");

    // hit coordinates stay within [0, 1]
    a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == rpi_pkg::ST_HIT)
        |-> (out_data.coord_u <= 17'h10000) && (out_data.coord_v <= 17'h10000))
        else $error("hit coordinate beyond one");

    // back-pressure only comes from a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("request stalled with no result waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

endmodule

bind ray_parallelogram_intersect_top rpi_checker u_rpi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[sim/ray_parallelogram_intersect_top_test.sv]
// Testbench for ray_parallelogram_intersect_top: drives ray requests and
// parallelogram writes, predicts each result and checks it in order.
// Depends on rpi_pkg and the block's RTL only.
`timescale 1ns / 100ps

module ray_parallelogram_intersect_top_test;

    // index with no register behind it; writes to it must be ignored
    localparam logic [rpi_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef longint vec3_t [3];

    // expected intersection results and the shape they are computed from
    class hit_scoreboard;
        rpi_pkg::cvec_t   corner;
        rpi_pkg::cvec_t   edge_u;
        rpi_pkg::cvec_t   edge_v;
        rpi_pkg::result_t expected_q[$];
        int               mismatches;

        function new();
            corner = '0;
            edge_u = '0;
            edge_v = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [rpi_pkg::CFG_IDX_W-1:0] idx,
                                logic [rpi_pkg::REG_W-1:0] val);
            case (idx)
                rpi_pkg::REG_CORNER: corner = val;
                rpi_pkg::REG_EDGE_U: edge_u = val;
                rpi_pkg::REG_EDGE_V: edge_v = val;
                default: ;
            endcase
        endfunction

        function vec3_t cross3(vec3_t a, vec3_t b);
            vec3_t r;
            r[0] = a[1] * b[2] - a[2] * b[1];
            r[1] = a[2] * b[0] - a[0] * b[2];
            r[2] = a[0] * b[1] - a[1] * b[0];
            return r;
        endfunction

        function longint dot3(vec3_t a, vec3_t b);
            return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        endfunction

        // floor(num * 2^16 / den), integer part capped at 65536
        function logic [63:0] fixed_ratio(longint unsigned num, longint unsigned den);
            longint unsigned ip;
            logic [127:0] rem;
            logic [63:0] frac;
            ip = num / den;
            rem = 128'(num % den);
            if (ip > 65536)
                ip = 65536;
            frac = 64'((rem << 16) / den);
            return (ip << 16) | frac;
        endfunction

        function longint unsigned mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function rpi_pkg::result_t predict(rpi_pkg::ray_t r);
            vec3_t p, eu, ev, o, d, w, n;
            longint det, tn, un, vn;
            logic [63:0] q;
            logic dneg;
            rpi_pkg::result_t res;
            p  = '{corner.x, corner.y, corner.z};
            eu = '{edge_u.x, edge_u.y, edge_u.z};
            ev = '{edge_v.x, edge_v.y, edge_v.z};
            o  = '{r.origin_x, r.origin_y, r.origin_z};
            d  = '{r.dir_x, r.dir_y, r.dir_z};
            for (int i = 0; i < 3; i++)
                w[i] = p[i] - o[i];
            res = '0;
            n = cross3(eu, ev);
            det = dot3(d, n);
            if (det == 0)
            begin
                res.status = rpi_pkg::ST_PARALLEL;
                return res;
            end
            dneg = det < 0;
            tn = dot3(w, n);
            un = dot3(d, cross3(ev, w));
            vn = dot3(d, cross3(w, eu));
            if ((un != 0 && (un < 0) != dneg) || mag(un) > mag(det) ||
                (vn != 0 && (vn < 0) != dneg) || mag(vn) > mag(det))
            begin
                res.status = rpi_pkg::ST_OUTSIDE;
                return res;
            end
            res.status = rpi_pkg::ST_HIT;
            q = fixed_ratio(mag(tn), mag(det));
            if (tn != 0 && (tn < 0) != dneg)
            begin
                if (q > 64'h8000_0000)
                    q = 64'h8000_0000;
                res.distance = 32'(-q);
            end
            else
            begin
                if (q > 64'h7FFF_FFFF)
                    q = 64'h7FFF_FFFF;
                res.distance = 32'(q);
            end
            res.coord_u = rpi_pkg::UV_W'(fixed_ratio(mag(un), mag(det)));
            res.coord_v = rpi_pkg::UV_W'(fixed_ratio(mag(vn), mag(det)));
            return res;
        endfunction

        function void note_ray(rpi_pkg::ray_t r);
            expected_q.push_back(predict(r));
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_result(rpi_pkg::result_t got);
            rpi_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", got.status, -1);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.distance !== want.distance)
                report("distance", got.distance, want.distance);
            if (got.coord_u !== want.coord_u)
                report("coord_u", got.coord_u, want.coord_u);
            if (got.coord_v !== want.coord_v)
                report("coord_v", got.coord_v, want.coord_v);
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [rpi_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rpi_pkg::REG_W-1:0]     cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    rpi_pkg::ray_t                 in_data;
    logic                          out_valid;
    logic                          out_ready;
    rpi_pkg::result_t              out_data;

    hit_scoreboard sb;
    int tx_idle;
    int rx_idle;

    ray_parallelogram_intersect_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // result side: random back-pressure, check on each accepted result
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(out_data);
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // one ray request, with random idle cycles ahead of it
    task automatic send_ray(rpi_pkg::ray_t r);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_ray(r);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [rpi_pkg::CFG_IDX_W-1:0] idx,
                             logic [rpi_pkg::REG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_shape(rpi_pkg::cvec_t p, rpi_pkg::cvec_t eu, rpi_pkg::cvec_t ev);
        write_reg(rpi_pkg::REG_CORNER, p);
        write_reg(rpi_pkg::REG_EDGE_U, eu);
        write_reg(rpi_pkg::REG_EDGE_V, ev);
    endtask

    function automatic rpi_pkg::coord_t rnd_coord(int lim);
        return rpi_pkg::coord_t'($urandom_range(2 * lim) - lim);
    endfunction

    function automatic rpi_pkg::cvec_t rnd_vec(int lim);
        rpi_pkg::cvec_t v;
        v.x = rnd_coord(lim);
        v.y = rnd_coord(lim);
        v.z = rnd_coord(lim);
        return v;
    endfunction

    function automatic rpi_pkg::ray_t make_ray(rpi_pkg::cvec_t o, rpi_pkg::cvec_t d);
        rpi_pkg::ray_t r;
        r.origin_x = o.x;
        r.origin_y = o.y;
        r.origin_z = o.z;
        r.dir_x = d.x;
        r.dir_y = d.y;
        r.dir_z = d.z;
        return r;
    endfunction

    // ray aimed near the parallelogram, from in front of or behind it
    function automatic rpi_pkg::ray_t aimed_ray();
        int a, b, k;
        int tgt [3];
        int pp [3], uu [3], vv [3], dd [3];
        rpi_pkg::cvec_t o, d;
        a = $urandom_range(12) - 2;
        b = $urandom_range(12) - 2;
        k = $urandom_range(6) - 2;
        d = rnd_vec(2000);
        pp = '{sb.corner.x, sb.corner.y, sb.corner.z};
        uu = '{sb.edge_u.x, sb.edge_u.y, sb.edge_u.z};
        vv = '{sb.edge_v.x, sb.edge_v.y, sb.edge_v.z};
        dd = '{d.x, d.y, d.z};
        for (int i = 0; i < 3; i++)
            tgt[i] = pp[i] + (a * uu[i]) / 8 + (b * vv[i]) / 8 - k * dd[i];
        o.x = rpi_pkg::coord_t'(tgt[0]);
        o.y = rpi_pkg::coord_t'(tgt[1]);
        o.z = rpi_pkg::coord_t'(tgt[2]);
        return make_ray(o, d);
    endfunction

    // direction in the plane of the edges
    function automatic rpi_pkg::ray_t parallel_ray();
        int a, b;
        rpi_pkg::cvec_t d;
        a = $urandom_range(4) - 2;
        b = $urandom_range(4) - 2;
        d.x = rpi_pkg::coord_t'(a * sb.edge_u.x + b * sb.edge_v.x);
        d.y = rpi_pkg::coord_t'(a * sb.edge_u.y + b * sb.edge_v.y);
        d.z = rpi_pkg::coord_t'(a * sb.edge_u.z + b * sb.edge_v.z);
        return make_ray(rnd_vec(8000), d);
    endfunction

    function automatic rpi_pkg::ray_t random_ray();
        rpi_pkg::ray_t r;
        r = rpi_pkg::ray_t'({$urandom, $urandom, $urandom});
        return r;
    endfunction

    function automatic rpi_pkg::ray_t mixed_ray();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return aimed_ray();
        if (pick < 80)
            return parallel_ray();
        return random_ray();
    endfunction

    // new shape between bursts; a few are degenerate or at the extremes
    task automatic random_shape();
        rpi_pkg::cvec_t p, eu, ev;
        int kind;
        kind = $urandom_range(9);
        p  = rnd_vec(4000);
        eu = rnd_vec(3000);
        ev = rnd_vec(3000);
        if (kind == 0)
            ev = eu;
        else if (kind == 1)
        begin
            p  = rpi_pkg::REG_W'({$urandom, $urandom});
            eu = rpi_pkg::REG_W'({$urandom, $urandom});
            ev = rpi_pkg::REG_W'({$urandom, $urandom});
        end
        else if (kind == 2)
        begin
            p  = {16'h7FFF, 16'h8000, 16'h7FFF};
            eu = {16'h8000, 16'h7FFF, 16'h7FFF};
            ev = {16'h7FFF, 16'h8000, 16'h8000};
        end
        set_shape(p, eu, ev);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                drain();
                random_shape();
            end
            send_ray(mixed_ray());
        end
    endtask

    initial
    begin
        sb = new();
        tx_idle   = 0;
        rx_idle   = 0;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset shape is all zero: every ray is parallel
        send_ray(random_ray());
        send_ray(make_ray({16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000}));
        drain();

        // unit square in the xy plane, corner high in z
        set_shape({16'h7FFF, 16'h0000, 16'h0000}, {16'h0, 16'h0, 16'h0100},
                  {16'h0, 16'h0100, 16'h0});
        write_reg(REG_NONE, {rpi_pkg::REG_W{1'b1}});
        // distance saturates high, then low with the direction reversed
        send_ray(make_ray({16'h8000, 16'h0, 16'h0}, {16'h0001, 16'h0, 16'h0}));
        send_ray(make_ray({16'h8000, 16'h0, 16'h0}, {16'hFFFF, 16'h0, 16'h0}));
        // a corner of the square, centre, just outside
        send_ray(make_ray({16'h0, 16'h0100, 16'h0100}, {16'h0100, 16'h0, 16'h0}));
        send_ray(make_ray({16'h0, 16'h0080, 16'h0080}, {16'h0100, 16'h0, 16'h0}));
        send_ray(make_ray({16'h0, 16'h0101, 16'h0080}, {16'h0100, 16'h0, 16'h0}));
        send_ray(make_ray({16'h0, 16'hFFFF, 16'h0080}, {16'h0100, 16'h0, 16'h0}));
        drain();
        // corner moved along x: a ray from the plane that misses, then a parallel one
        write_reg(rpi_pkg::REG_CORNER, {16'h0, 16'h0, 16'hFF00});
        send_ray(make_ray({16'h0, 16'h0040, 16'h0040}, {16'h0200, 16'h0, 16'h0}));
        send_ray(make_ray({16'h0, 16'h0040, 16'h0040}, {16'h0, 16'h0100, 16'h0}));
        // field extremes
        send_ray(make_ray({16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF}));
        send_ray(make_ray({16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000}));
        send_ray(make_ray({16'h0, 16'h0, 16'h0}, {16'h8000, 16'h0, 16'h0}));
        for (int i = 0; i < 8; i++)
            send_ray(mixed_ray());

        tx_idle = 12;
        rx_idle = 76;
        random_phase(700);
        tx_idle = 76;
        rx_idle = 12;
        random_phase(600);
        tx_idle = 0;
        rx_idle = 0;
        random_phase(700);

        drain();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
